// File: src/max_pool_2x2_assert.svh
// assertion macros for the 2x2 max pooling block
`ifndef MAX_POOL_2X2_ASSERT_SVH
`define MAX_POOL_2X2_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MP2_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("max_pool_2x2 check failed");
`define MP2_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("max_pool_2x2 check failed");
`else
`define MP2_ASSERT_NOW(label, ante, cons)
`define MP2_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/mp2_pkg.sv
`default_nettype none

package mp2_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_OUT_DIM = 32;
	localparam logic [6:0] ROW_SAT = 7'd127;

	// reciprocal of three, scaled by 2**14, rounded up
	localparam int DIV3_SHIFT = 14;
	localparam logic [12:0] DIV3_RECIP = 13'd5462;

	// register indexes
	localparam logic [2:0] REG_IN_COLS     = 3'd0;
	localparam logic [2:0] REG_OUT_ROWS    = 3'd1;
	localparam logic [2:0] REG_OUT_COLS    = 3'd2;
	localparam logic [2:0] REG_STRIDE_ROWS = 3'd3;
	localparam logic [2:0] REG_STRIDE_COLS = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          end_of_tile;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pooled_value;
		logic [4:0]                    out_row;
		logic [4:0]                    out_col;
		logic                          last_of_tile;
	} out_item_t;

	typedef struct packed {
		logic [11:0] quo;
		logic [1:0]  rem;
	} div_res_t;

	// quotient and remainder by a stride of 1 to 4
	function automatic div_res_t div_stride(input logic [11:0] num, input logic [2:0] stride);
		logic [25:0] prod;
		div_res_t    res;
		prod = 26'(num) * 26'(DIV3_RECIP);
		unique case (stride)
			3'd1: begin
				res.quo = num;
				res.rem = 2'd0;
			end
			3'd2: begin
				res.quo = num >> 1;
				res.rem = {1'b0, num[0]};
			end
			3'd3: begin
				res.quo = prod[DIV3_SHIFT +: 12];
				res.rem = 2'(num - (res.quo << 1) - res.quo);
			end
			default: begin
				res.quo = num >> 2;
				res.rem = num[1:0];
			end
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/max_pool_2x2.sv
// channel  | direction | handshake           | payload
// in       | input     | in_valid / in_stall   | mp2_pkg::in_item_t
// out      | output    | out_valid / out_stall | mp2_pkg::out_item_t
// config   | input     | apb write/read        | pwdata / prdata, 32 bits
//
// one item per cycle unless stalled; results go via stage one to output register
// line buffer read and write both happen on the accept edge, read data registered
// stage one holds one item; it stalls the input only while it holds a result
// and the output register is full and stalled
// reset clears counters and valid flags, loads config defaults; line buffer kept
`default_nettype none

`include "max_pool_2x2_assert.svh"

module max_pool_2x2 #(
	parameter int MAX_COLS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire mp2_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output mp2_pkg::out_item_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int CLW = $clog2(MAX_COLS + 1);
	localparam int SB  = mp2_pkg::SAMPLE_BITS;

	logic [6:0] in_cols_q;
	logic [5:0] out_rows_q;
	logic [5:0] out_cols_q;
	logic [2:0] stride_rows_q;
	logic [2:0] stride_cols_q;

	logic [6:0]    row_count_q;
	logic [CW-1:0] col_count_q;

	logic signed [SB-1:0] row_mem [MAX_COLS];

	logic                 valid_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic [4:0]           prow_s1;
	logic [4:0]           pcol_s1;
	logic signed [SB-1:0] sample_s1;
	logic signed [SB-1:0] above_s1;

	logic signed [SB-1:0] left_q;
	logic signed [SB-1:0] left_above_q;

	mp2_pkg::out_item_t out_data_q;
	logic               out_valid_q;

	logic            accept;
	logic            advance2;
	logic            cfg_write;
	logic [CLW-1:0]  cols;
	logic [5:0]      orows;
	logic [5:0]      ocols;
	logic [2:0]      srows;
	logic [2:0]      scols;
	logic            wrap;
	logic [6:0]      cur_row;
	logic [CW-1:0]   cur_col;
	logic [6:0]      next_row;
	logic [CW-1:0]   next_col;
	mp2_pkg::div_res_t row_div;
	mp2_pkg::div_res_t col_div;
	logic            emit;
	logic            last;
	logic signed [SB-1:0] max_top;
	logic signed [SB-1:0] max_bot;
	logic signed [SB-1:0] max_all;

	// config port
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cols_q     <= 7'd32;
			out_rows_q    <= 6'd16;
			out_cols_q    <= 6'd16;
			stride_rows_q <= 3'd2;
			stride_cols_q <= 3'd2;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				mp2_pkg::REG_IN_COLS:     in_cols_q     <= pwdata[6:0];
				mp2_pkg::REG_OUT_ROWS:    out_rows_q    <= pwdata[5:0];
				mp2_pkg::REG_OUT_COLS:    out_cols_q    <= pwdata[5:0];
				mp2_pkg::REG_STRIDE_ROWS: stride_rows_q <= pwdata[2:0];
				mp2_pkg::REG_STRIDE_COLS: stride_cols_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			mp2_pkg::REG_IN_COLS:     prdata = 32'(in_cols_q);
			mp2_pkg::REG_OUT_ROWS:    prdata = 32'(out_rows_q);
			mp2_pkg::REG_OUT_COLS:    prdata = 32'(out_cols_q);
			mp2_pkg::REG_STRIDE_ROWS: prdata = 32'(stride_rows_q);
			mp2_pkg::REG_STRIDE_COLS: prdata = 32'(stride_cols_q);
			default:                  prdata = 32'd0;
		endcase
	end

	// handshakes
	assign advance2 = valid_s1 & (~emit_s1 | ~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance2;
	assign accept   = in_valid & ~in_stall;

	// position of the incoming sample and window test
	always_comb begin
		if (in_cols_q < 7'd2) begin
			cols = CLW'(2);
		end else if (32'(in_cols_q) > MAX_COLS) begin
			cols = CLW'(MAX_COLS);
		end else begin
			cols = CLW'(in_cols_q);
		end
		orows = (out_rows_q > 6'(mp2_pkg::MAX_OUT_DIM)) ? 6'(mp2_pkg::MAX_OUT_DIM) : out_rows_q;
		ocols = (out_cols_q > 6'(mp2_pkg::MAX_OUT_DIM)) ? 6'(mp2_pkg::MAX_OUT_DIM) : out_cols_q;
		srows = (stride_rows_q == 3'd0) ? 3'd1 : ((stride_rows_q > 3'd4) ? 3'd4 : stride_rows_q);
		scols = (stride_cols_q == 3'd0) ? 3'd1 : ((stride_cols_q > 3'd4) ? 3'd4 : stride_cols_q);

		wrap = CLW'(col_count_q) >= cols;
		if (wrap) begin
			cur_col = '0;
			cur_row = (row_count_q == mp2_pkg::ROW_SAT) ? row_count_q : row_count_q + 7'd1;
		end else begin
			cur_col = col_count_q;
			cur_row = row_count_q;
		end

		if (CLW'(cur_col) + CLW'(1) >= cols) begin
			next_col = '0;
			next_row = (cur_row == mp2_pkg::ROW_SAT) ? cur_row : cur_row + 7'd1;
		end else begin
			next_col = cur_col + CW'(1);
			next_row = cur_row;
		end

		row_div = mp2_pkg::div_stride(12'(cur_row - 7'd1), srows);
		col_div = mp2_pkg::div_stride(12'(cur_col - CW'(1)), scols);
		emit = (cur_row != 7'd0) && (cur_col != '0) &&
			(row_div.rem == 2'd0) && (col_div.rem == 2'd0) &&
			(row_div.quo < 12'(orows)) && (col_div.quo < 12'(ocols));
		last = (row_div.quo == 12'(orows) - 12'd1) && (col_div.quo == 12'(ocols) - 12'd1);
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
		end else if (accept) begin
			if (in_data.end_of_tile) begin
				row_count_q <= '0;
				col_count_q <= '0;
			end else begin
				row_count_q <= next_row;
				col_count_q <= next_col;
			end
		end
	end

	// line buffer and stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1         <= row_mem[cur_col];
			row_mem[cur_col] <= in_data.sample;
			sample_s1        <= in_data.sample;
			emit_s1          <= emit;
			last_s1          <= last;
			prow_s1          <= row_div.quo[4:0];
			pcol_s1          <= col_div.quo[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			left_q       <= '0;
			left_above_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance2) begin
				valid_s1 <= 1'b0;
			end
			if (advance2) begin
				left_q       <= sample_s1;
				left_above_q <= above_s1;
			end
		end
	end

	// maximum of the window
	always_comb begin
		max_top = (left_above_q > above_s1) ? left_above_q : above_s1;
		max_bot = (left_q > sample_s1) ? left_q : sample_s1;
		max_all = (max_top > max_bot) ? max_top : max_bot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance2 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance2 && emit_s1) begin
			out_data_q.pooled_value <= max_all;
			out_data_q.out_row      <= prow_s1;
			out_data_q.out_col      <= pcol_s1;
			out_data_q.last_of_tile <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`MP2_ASSERT_NOW(a_stall_only_when_blocked, in_stall, valid_s1 && emit_s1 && out_valid_q && out_stall)
	`MP2_ASSERT_NEXT(a_accept_fills_s1, accept, valid_s1)
	`MP2_ASSERT_NEXT(a_result_loaded, advance2 && emit_s1, out_valid_q)
	`MP2_ASSERT_NEXT(a_tile_end_clears, accept && in_data.end_of_tile, row_count_q == 7'd0 && col_count_q == '0)
	`MP2_ASSERT_NEXT(a_row_monotonic, accept && !in_data.end_of_tile, row_count_q >= $past(row_count_q))

endmodule

`default_nettype wire
